FILE: sv/nd3_pkg.sv
package nd3_pkg;

   // input opcodes
   localparam logic OP_TABLE = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // configuration register indexes
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // reset values of the configuration registers
   localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
   localparam logic [12:0] FRAME_HEIGHT_RST = 13'd4096;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // saturation ceiling of the Q8.8 result
   localparam logic [15:0] VALUE_MAX = 16'd65280;

   // one queued transaction: a table write or a pixel with its three window columns
   typedef struct packed {
      logic             op;
      logic [7:0]       tbl_index;
      logic [13:0]      tbl_weight;
      logic [2:0][7:0]  col_a;
      logic [2:0][7:0]  col_b;
      logic [2:0][7:0]  col_c;
      logic [15:0]      row;
      logic [12:0]      column;
      logic             last_row;
      logic             last_column;
   } entry_type;

endpackage

FILE: sv/nd3_front.sv
module nd3_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [7:0]         req_table_index,
   input  logic [13:0]        req_table_weight,
   input  logic [7:0]         req_pixel,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [12:0]        csr_data,
   output logic               push,
   output nd3_pkg::entry_type push_entry,
   input  logic               q_full
);
   import nd3_pkg::*;

   localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

   logic [10:0]      fw_ff;
   logic [12:0]      fh_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic             f1_valid_ff;
   logic             f1_op_ff;
   logic [7:0]       f1_idx_ff;
   logic [13:0]      f1_wt_ff;
   logic [7:0]       f1_pix_ff;
   logic [CW-1:0]    f1_col_ff;
   logic [RW-1:0]    f1_row_ff;
   logic             f1_lastc_ff;
   logic             f1_lastr_ff;
   logic [7:0]       up_rd_ff;
   logic [7:0]       mid_rd_ff;
   logic [2:0][7:0]  win_a_ff;
   logic [2:0][7:0]  win_b_ff;
   logic [2:0][7:0]  cur;
   logic [7:0]       upper_mem  [MAX_WIDTH];
   logic [7:0]       middle_mem [MAX_WIDTH];
   logic [16:0]      w_eff, h_eff;
   logic             lastc, lastr;
   logic             accept, f1_go, f1_pixel;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= FRAME_WIDTH_RST;
         fh_ff <= FRAME_HEIGHT_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH:  fw_ff <= csr_data[10:0];
            REG_FRAME_HEIGHT: fh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // clamped frame size
   always_comb begin
      w_eff = 17'(fw_ff);
      if (w_eff < 17'd2) w_eff = 17'd2;
      if (w_eff > 17'(MAX_WIDTH)) w_eff = 17'(MAX_WIDTH);
      h_eff = 17'(fh_ff);
      if (h_eff < 17'd2) h_eff = 17'd2;
      if (h_eff > 17'(MAX_HEIGHT)) h_eff = 17'(MAX_HEIGHT);
   end

   assign lastc = (17'(col_ff) + 17'd1) >= w_eff;
   assign lastr = (17'(row_ff) + 17'd1) >= h_eff;

   // handshake
   assign f1_go     = f1_valid_ff && !q_full;
   assign req_stall = f1_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign f1_pixel  = f1_op_ff == OP_PIXEL;

   // raster counters advance on each accepted pixel
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept && req_op == OP_PIXEL) begin
         if (lastc) begin
            col_in = '0;
            row_in = lastr ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // first stage holds the accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (accept) begin
         f1_valid_ff <= 1'b1;
      end else if (f1_go) begin
         f1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_op_ff    <= req_op;
         f1_idx_ff   <= req_table_index;
         f1_wt_ff    <= req_table_weight;
         f1_pix_ff   <= req_pixel;
         f1_col_ff   <= col_ff;
         f1_row_ff   <= row_ff;
         f1_lastc_ff <= lastc;
         f1_lastr_ff <= lastr;
      end
   end

   // line buffers: read on accept, write back when the pixel leaves
   always_ff @(posedge clock) begin
      if (accept && req_op == OP_PIXEL) begin
         up_rd_ff  <= upper_mem[col_ff];
         mid_rd_ff <= middle_mem[col_ff];
      end
      if (f1_go && f1_pixel) begin
         upper_mem[f1_col_ff]  <= mid_rd_ff;
         middle_mem[f1_col_ff] <= f1_pix_ff;
      end
   end

   // current column top to bottom; row one repeats the top border
   assign cur[0] = (f1_row_ff == RW'(1)) ? mid_rd_ff : up_rd_ff;
   assign cur[1] = mid_rd_ff;
   assign cur[2] = f1_pix_ff;

   // window of the two previous columns
   always_ff @(posedge clock) begin
      if (reset) begin
         win_a_ff <= '0;
         win_b_ff <= '0;
      end else if (f1_go && f1_pixel) begin
         win_a_ff <= (f1_col_ff == '0) ? cur : win_b_ff;
         win_b_ff <= cur;
      end
   end

   // queue entry
   assign push = f1_go && (!f1_pixel || (f1_col_ff != '0 && f1_row_ff != '0));

   always_comb begin
      push_entry             = '0;
      push_entry.op          = f1_op_ff;
      push_entry.tbl_index   = f1_idx_ff;
      push_entry.tbl_weight  = f1_wt_ff;
      push_entry.col_a       = win_a_ff;
      push_entry.col_b       = win_b_ff;
      push_entry.col_c       = cur;
      push_entry.row         = 16'(f1_row_ff);
      push_entry.column      = 13'(f1_col_ff);
      push_entry.last_row    = f1_lastr_ff;
      push_entry.last_column = f1_lastc_ff;
   end

endmodule

FILE: sv/nd3_queue.sv
module nd3_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  nd3_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output nd3_pkg::entry_type head_entry
);
   import nd3_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   entry_type      slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ff, rd_ff;
   logic [PW:0]    count_ff;
   logic           do_pop;

   assign full       = count_ff == (PW+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_entry;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push)   wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         case ({push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: sv/nd3_back.sv
module nd3_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  nd3_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_value_q8,
   output logic [11:0]        rsp_out_row,
   output logic [9:0]         rsp_out_column,
   output logic               rsp_frame_last
);
   import nd3_pkg::*;

   logic                    adv;
   logic [1:0]              k_ff, k_next;
   logic [3:0]              mask;
   logic                    done;
   logic                    is_write, is_job;
   logic [2:0][7:0]         lc, mc, rc;
   logic [2:0][7:0]         g0, g1, g2;
   logic [7:0]              nb [8];
   logic [7:0]              center;
   logic signed [8:0]       diff [8];
   logic [7:0]              addr [8];
   logic [15:0]             row_tag;
   logic [12:0]             col_tag;

   logic                    s1_valid_ff;
   logic signed [8:0]       s1_diff_ff [8];
   logic [7:0]              s1_p_ff;
   logic [11:0]             s1_row_ff;
   logic [9:0]              s1_col_ff;
   logic                    s1_last_ff;
   logic [13:0]             s1_wt_ff [8];

   logic signed [27:0]      acc;
   logic                    s2_valid_ff;
   logic signed [27:0]      s2_acc_ff;
   logic [11:0]             s2_row_ff;
   logic [9:0]              s2_col_ff;
   logic                    s2_last_ff;

   logic [19:0]             rounded;
   logic [15:0]             value_in;
   logic                    rsp_valid_ff;
   logic [15:0]             rsp_value_ff;
   logic [11:0]             rsp_row_ff;
   logic [9:0]              rsp_col_ff;
   logic                    rsp_last_ff;

   // whole pipeline moves unless a held result is stalled
   assign adv = !rsp_valid_ff || !rsp_stall;

   // result sequencer over the up to four windows of one entry
   assign is_write = head_valid && head_entry.op == OP_TABLE;
   assign is_job   = head_valid && head_entry.op == OP_PIXEL;
   assign mask     = {head_entry.last_column && head_entry.last_row,
                      head_entry.last_column, head_entry.last_row, 1'b1};

   always_comb begin
      k_next = k_ff;
      done   = 1'b1;
      for (int j = 3; j >= 1; j--) begin
         if (2'(j) > k_ff && mask[j]) begin
            k_next = 2'(j);
            done   = 1'b0;
         end
      end
   end

   assign pop = adv && head_valid && (is_write || done);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (adv && is_job) begin
         k_ff <= done ? 2'd0 : k_next;
      end
   end

   // window selection: upper windows use (a,b,c), last-column ones (b,c,c)
   always_comb begin
      lc = k_ff[1] ? head_entry.col_b : head_entry.col_a;
      mc = k_ff[1] ? head_entry.col_c : head_entry.col_b;
      rc = head_entry.col_c;
      if (k_ff[0]) begin
         g0 = {rc[1], mc[1], lc[1]};
         g1 = {rc[2], mc[2], lc[2]};
         g2 = {rc[2], mc[2], lc[2]};
      end else begin
         g0 = {rc[0], mc[0], lc[0]};
         g1 = {rc[1], mc[1], lc[1]};
         g2 = {rc[2], mc[2], lc[2]};
      end
      center = g1[1];
      nb[0] = g0[0]; nb[1] = g0[1]; nb[2] = g0[2];
      nb[3] = g1[0]; nb[4] = g1[2];
      nb[5] = g2[0]; nb[6] = g2[1]; nb[7] = g2[2];
      for (int n = 0; n < 8; n++) begin
         diff[n] = $signed({1'b0, nb[n]}) - $signed({1'b0, center});
         addr[n] = diff[n][8] ? 8'(-diff[n]) : diff[n][7:0];
      end
   end

   // result tags: lower rows keep the row, last-column windows keep the column
   assign row_tag = k_ff[0] ? head_entry.row : head_entry.row - 16'd1;
   assign col_tag = k_ff[1] ? head_entry.column : head_entry.column - 13'd1;

   // weight table, one copy per neighbour lookup, all written together
   for (genvar n = 0; n < 8; n++) begin : g_tbl
      logic [13:0] tbl_mem [256];
      always_ff @(posedge clock) begin
         if (adv && is_write) tbl_mem[head_entry.tbl_index] <= head_entry.tbl_weight;
         if (adv && is_job)   s1_wt_ff[n] <= tbl_mem[addr[n]];
      end
   end

   // stage one: differences and tags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= is_job;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && is_job) begin
         for (int n = 0; n < 8; n++) s1_diff_ff[n] <= diff[n];
         s1_p_ff    <= center;
         s1_row_ff  <= row_tag[11:0];
         s1_col_ff  <= col_tag[9:0];
         s1_last_ff <= k_ff == 2'd3;
      end
   end

   // weighted sum of the neighbour differences on top of the centre
   always_comb begin
      acc = $signed(28'({s1_p_ff, 16'd0}));
      for (int n = 0; n < 8; n++) begin
         acc = acc + 28'($signed({1'b0, s1_wt_ff[n]}) * s1_diff_ff[n]);
      end
   end

   // stage two: accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         s2_acc_ff  <= acc;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // round half up to Q8.8 and saturate
   assign rounded = 20'((s2_acc_ff + 28'sd128) >>> 8);

   always_comb begin
      if (s2_acc_ff < 0) begin
         value_in = '0;
      end else if (rounded > 20'(VALUE_MAX)) begin
         value_in = VALUE_MAX;
      end else begin
         value_in = rounded[15:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         rsp_value_ff <= value_in;
         rsp_row_ff   <= s2_row_ff;
         rsp_col_ff   <= s2_col_ff;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_q8   = rsp_value_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_column = rsp_col_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

FILE: sv/nonlinear_diffusion_3x3.sv
// One explicit step of nonlinear diffusion over an 8-bit greyscale frame.
// Request channel (req_*): op selects a weight table write (table_index,
// table_weight in Q0.16) or the next pixel of the frame in raster order.
// Table writes take effect in order with the pixels around them.
// Response channel (rsp_*): filtered value in Q8.8 with its row and column;
// frame_last marks the bottom-right pixel. A pixel in row 0 or column 0
// gives nothing; other pixels give one result, the last row and the last
// column up to four, one per cycle while rsp_stall is low.
// csr_*: frame_width (index 0) and frame_height (index 1), written while idle.
// Throughput: one transaction per cycle while req_stall is low; a pixel with
// n results holds the back end until all n are given, and the four-entry
// queue absorbs the difference. Registers on the way to a result: line
// buffer read, queue, table lookup, accumulate, round; further results
// follow one a cycle while rsp_stall is low.
// Reset clears counters, window, queue and pipeline; line buffers and the
// weight table keep undefined content until written.
// A stalled response holds the whole back pipeline; the front keeps taking
// transactions until the queue fills, then raises req_stall.
module nonlinear_diffusion_3x3 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_table_index,
   input  logic [13:0] req_table_weight,
   input  logic [7:0]  req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_value_q8,
   output logic [11:0] rsp_out_row,
   output logic [9:0]  rsp_out_column,
   output logic        rsp_frame_last,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [12:0] csr_data
);
   import nd3_pkg::*;

   logic      push, q_full, pop, head_valid;
   entry_type push_entry, head_entry;

   // front: configuration, counters, line buffers, window
   nd3_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_table_index (req_table_index),
      .req_table_weight(req_table_weight),
      .req_pixel       (req_pixel),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .push            (push),
      .push_entry      (push_entry),
      .q_full          (q_full)
   );

   // decoupling queue
   nd3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (q_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_entry(head_entry)
   );

   // back: weight lookup, weighted sum, rounding
   nd3_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_q8  (rsp_value_q8),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_column(rsp_out_column),
      .rsp_frame_last(rsp_frame_last)
   );

endmodule

FILE: sv/nd3_checker.sv
module nd3_assertions (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_value_q8,
   input logic [11:0] rsp_out_row,
   input logic [9:0]  rsp_out_column,
   input logic        rsp_frame_last
);
   import nd3_pkg::*;

   // a stalled result stays offered
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped under stall");

   // a stalled result keeps its payload
   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_value_q8) && $stable(rsp_out_row)
         && $stable(rsp_out_column) && $stable(rsp_frame_last))
      else $error("response payload changed under stall");

   // saturation keeps values within the Q8.8 grey range
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_value_q8 <= VALUE_MAX)
      else $error("response value above saturation");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind nonlinear_diffusion_3x3 nd3_assertions u_nd3_assertions (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_value_q8  (rsp_value_q8),
   .rsp_out_row   (rsp_out_row),
   .rsp_out_column(rsp_out_column),
   .rsp_frame_last(rsp_frame_last)
);
